// ===== rtl/sbda_pkg.sv =====
package sbda_pkg;

    localparam int SBDA_LIMBS  = 2;
    localparam int LIMB_W      = 64;
    localparam int BIT_CNT_W   = $clog2(LIMB_W);

    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

    typedef struct packed {
        logic [LIMB_W-1:0] limb;
        logic              last_limb;
    } limb_item_t;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       last_char;
    } char_item_t;

    typedef enum logic [1:0] {
        CM_HOLD   = 2'd0,
        CM_CLEAR  = 2'd1,
        CM_DABBLE = 2'd2,
        CM_SHIFT  = 2'd3
    } cell_mode_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_NEG  = 6'b000010,
        ST_CONV = 6'b000100,
        ST_SKIP = 6'b001000,
        ST_SIGN = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

endpackage

// ===== rtl/sbda_cell.sv =====
module sbda_cell
    import sbda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_mode_t mode,
    input  logic       carry_in,
    input  logic [3:0] digit_in,
    output logic       carry_out,
    output logic [3:0] digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // add 3 when above 4; bit 3 of the adjusted digit moves to the next cell
    assign adj       = (digit_reg > 4'd4) ? (digit_reg + 4'd3) : digit_reg;
    assign carry_out = adj[3];
    assign digit     = digit_reg;

    always_comb
    begin
        unique case (mode)
            CM_CLEAR:  digit_next = 4'd0;
            CM_DABBLE: digit_next = {adj[2:0], carry_in};
            CM_SHIFT:  digit_next = digit_in;
            default:   digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 4'd0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== rtl/signed_binary_to_decimal_ascii.sv =====
// Sequence: a number of n limbs is first negated limb by limb (negative numbers only),
// then run through double dabble over all 64*n bits; up to NDIGITS-1 leading zeros are
// skipped, then one character per cycle leaves, the sign first, while the
// output is not stalled; each character is registered before it reaches the port.
// Throughput: one limb per cycle while loading; one number at a time after the last limb.
// Reset: asynchronous, active low; clears the sequencer, limb count, digits and output valid.
module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
#(
    parameter int LIMBS = SBDA_LIMBS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       limb_valid,
    output logic       limb_stall,
    input  limb_item_t limb_data,
    output logic       char_valid,
    input  logic       char_stall,
    output char_item_t char_data
);

    localparam int NDIGITS = (LIMBS * 1927) / 100 + 1;
    localparam int IDX_W   = (LIMBS > 1) ? $clog2(LIMBS) : 1;
    localparam int CNT_W   = $clog2(LIMBS + 1);
    localparam int REM_W   = $clog2(NDIGITS + 1);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      loaded_reg, loaded_next;
    logic [CNT_W-1:0]      nlimbs_reg, nlimbs_next;
    logic                  neg_reg, neg_next;
    logic                  carry_reg, carry_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [BIT_CNT_W-1:0]  bit_reg, bit_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic                  out_valid_reg, out_valid_next;
    char_item_t            out_reg, out_next;

    logic [LIMB_W-1:0]     limb_reg [LIMBS];
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [LIMB_W-1:0]     wr_data;
    logic [LIMB_W-1:0]     rd_limb;
    logic [LIMB_W-1:0]     neg_limb;

    cell_mode_t            mode;
    logic                  bit_in;
    logic [3:0]            digit_w [NDIGITS];
    logic                  carry_w [NDIGITS];
    logic [3:0]            top_digit;

    logic                  accept;
    logic                  ends_number;
    logic                  sign_bit;
    logic                  out_free;

    assign limb_stall = (state_reg != ST_IDLE);
    assign accept     = limb_valid && !limb_stall;
    assign out_free   = !out_valid_reg || !char_stall;
    assign char_valid = out_valid_reg;
    assign char_data  = out_reg;

    assign rd_limb  = limb_reg[idx_reg];
    assign neg_limb = ~rd_limb + {{(LIMB_W-1){1'b0}}, carry_reg};
    assign ends_number = limb_data.last_limb || (loaded_reg == CNT_W'(LIMBS - 1));
    assign sign_bit = (loaded_reg == '0) ? limb_data.limb[LIMB_W-1] : limb_reg[0][LIMB_W-1];
    assign top_digit = digit_w[NDIGITS-1];

    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        nlimbs_next    = nlimbs_reg;
        neg_next       = neg_reg;
        carry_next     = carry_reg;
        idx_next       = idx_reg;
        bit_next       = bit_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && char_stall;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_idx         = idx_reg;
        wr_data        = rd_limb;
        mode           = CM_HOLD;
        bit_in         = rd_limb[LIMB_W-1];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    wr_en   = 1'b1;
                    wr_idx  = loaded_reg[IDX_W-1:0];
                    wr_data = limb_data.limb;
                    if (ends_number)
                    begin
                        nlimbs_next = loaded_reg + CNT_W'(1);
                        loaded_next = '0;
                        neg_next    = sign_bit;
                        carry_next  = 1'b1;
                        mode        = CM_CLEAR;
                        if (sign_bit)
                        begin
                            state_next = ST_NEG;
                            idx_next   = loaded_reg[IDX_W-1:0];
                        end
                        else
                        begin
                            state_next = ST_CONV;
                            idx_next   = '0;
                            bit_next   = BIT_CNT_W'(LIMB_W - 1);
                        end
                    end
                    else
                    begin
                        loaded_next = loaded_reg + CNT_W'(1);
                    end
                end
            end
            ST_NEG:
            begin
                // least significant limb first, carry ripples upward
                wr_en      = 1'b1;
                wr_data    = neg_limb;
                carry_next = carry_reg && (neg_limb == '0);
                if (idx_reg == '0)
                begin
                    state_next = ST_CONV;
                    bit_next   = BIT_CNT_W'(LIMB_W - 1);
                end
                else
                begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            ST_CONV:
            begin
                mode    = CM_DABBLE;
                wr_en   = 1'b1;
                wr_data = {rd_limb[LIMB_W-2:0], 1'b0};
                if (bit_reg == '0)
                begin
                    if ((CNT_W'(idx_reg) + CNT_W'(1)) == nlimbs_reg)
                    begin
                        state_next = ST_SKIP;
                        rem_next   = REM_W'(NDIGITS);
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        bit_next = BIT_CNT_W'(LIMB_W - 1);
                    end
                end
                else
                begin
                    bit_next = bit_reg - BIT_CNT_W'(1);
                end
            end
            ST_SKIP:
            begin
                if ((top_digit == 4'd0) && (rem_reg != REM_W'(1)))
                begin
                    mode     = CM_SHIFT;
                    rem_next = rem_reg - REM_W'(1);
                end
                else if (neg_reg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.ascii_char = ASCII_MINUS;
                    out_next.last_char  = 1'b0;
                    state_next          = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.ascii_char = {ASCII_DIGIT_HI, top_digit};
                    out_next.last_char  = (rem_reg == REM_W'(1));
                    mode                = CM_SHIFT;
                    rem_next            = rem_reg - REM_W'(1);
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            loaded_reg    <= '0;
            nlimbs_reg    <= '0;
            neg_reg       <= 1'b0;
            carry_reg     <= 1'b0;
            idx_reg       <= '0;
            bit_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            nlimbs_reg    <= nlimbs_next;
            neg_reg       <= neg_next;
            carry_reg     <= carry_next;
            idx_reg       <= idx_next;
            bit_reg       <= bit_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (wr_en)
        begin
            limb_reg[wr_idx] <= wr_data;
        end
    end

    // digit row, least significant digit in cell 0
    genvar k;
    generate
        for (k = 0; k < NDIGITS; k++)
        begin : g_cell
            if (k == 0)
            begin : g_first
                sbda_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .mode      (mode),
                    .carry_in  (bit_in),
                    .digit_in  (4'd0),
                    .carry_out (carry_w[k]),
                    .digit     (digit_w[k])
                );
            end
            else
            begin : g_next
                sbda_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .mode      (mode),
                    .carry_in  (carry_w[k-1]),
                    .digit_in  (digit_w[k-1]),
                    .carry_out (carry_w[k]),
                    .digit     (digit_w[k])
                );
            end
        end
    endgenerate

endmodule

// ===== rtl/sbda_checker.sv =====
module sbda_checker
    import sbda_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       limb_valid,
    input logic       limb_stall,
    input limb_item_t limb_data,
    input logic       char_valid,
    input logic       char_stall,
    input char_item_t char_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid && $stable(char_data))
        else $error("stalled character changed");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (char_data.ascii_char == ASCII_MINUS) ||
                       ((char_data.ascii_char >= 8'h30) && (char_data.ascii_char <= 8'h39)))
        else $error("character outside sign and digits");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && (char_data.ascii_char == ASCII_MINUS) |-> !char_data.last_char)
        else $error("minus sign marked as last character");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        limb_valid && !limb_stall && limb_data.last_limb |=> limb_stall)
        else $error("new limb taken while converting");

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (.*);

// ===== tb/sv/signed_binary_to_decimal_ascii_test.sv =====
module signed_binary_to_decimal_ascii_test;
    import sbda_pkg::*;

    localparam int WIDE = LIMB_W * SBDA_LIMBS;
    localparam int unsigned CYCLE_LIMIT = 400000;

    class char_scoreboard;
        logic [LIMB_W-1:0] limbs [SBDA_LIMBS];
        int unsigned loaded = 0;
        int unsigned errors = 0;
        char_item_t expected_q [$];

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // a limb that ends the number queues its whole decimal string
        function void note_limb(limb_item_t it);
            logic [WIDE-1:0] value;
            logic [WIDE-1:0] mask;
            logic            neg;
            int unsigned     n;
            logic [3:0]      digits [$];
            char_item_t      c;
            if (loaded >= SBDA_LIMBS)
                loaded = 0;
            limbs[loaded] = it.limb;
            loaded++;
            if (!it.last_limb && loaded < SBDA_LIMBS)
                return;
            n = loaded;
            loaded = 0;
            value = '0;
            for (int i = 0; i < n; i++)
                value = (value << LIMB_W) | WIDE'(limbs[i]);
            mask = {WIDE{1'b1}} >> (LIMB_W * (SBDA_LIMBS - n));
            neg = limbs[0][LIMB_W-1];
            if (neg)
                value = (~value + 1'b1) & mask;
            do
            begin
                digits.push_front(4'(value % 10));
                value = value / 10;
            end
            while (value != 0);
            if (neg)
            begin
                c.ascii_char = ASCII_MINUS;
                c.last_char = 1'b0;
                expected_q.push_back(c);
            end
            foreach (digits[i])
            begin
                c.ascii_char = {ASCII_DIGIT_HI, digits[i]};
                c.last_char = (i == digits.size() - 1);
                expected_q.push_back(c);
            end
        endfunction

        function void check_char(char_item_t got);
            char_item_t want;
            if (expected_q.size() == 0)
            begin
                $error("ascii_char: no transfer expected, actual %h", got.ascii_char);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.ascii_char !== want.ascii_char)
            begin
                $error("ascii_char: expected %h, actual %h", want.ascii_char, got.ascii_char);
                errors++;
            end
            if (got.last_char !== want.last_char)
            begin
                $error("last_char: expected %b, actual %b", want.last_char, got.last_char);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       limb_valid;
    logic       limb_stall;
    limb_item_t limb_data;
    logic       char_valid;
    logic       char_stall;
    char_item_t char_data;

    char_scoreboard sb;
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned cycles = 0;

    signed_binary_to_decimal_ascii #(
        .LIMBS(SBDA_LIMBS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .limb_valid(limb_valid),
        .limb_stall(limb_stall),
        .limb_data(limb_data),
        .char_valid(char_valid),
        .char_stall(char_stall),
        .char_data(char_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        char_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && char_valid && !char_stall)
                sb.check_char(char_data);
            char_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_limb(input logic [LIMB_W-1:0] value, input logic last);
        limb_item_t it;
        it.limb = value;
        it.last_limb = last;
        while ($urandom_range(99) < idle_pct)
        begin
            limb_valid <= 1'b0;
            @(posedge clk);
        end
        limb_valid <= 1'b1;
        limb_data <= it;
        @(posedge clk);
        while (limb_stall)
            @(posedge clk);
        sb.note_limb(it);
    endtask

    task automatic drain();
        limb_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [LIMB_W-1:0] v;
        logic              lst;
        int unsigned       n;
        int unsigned       sent;
        sb = new;
        sent = 0;
        idle_pct = 6;
        stall_pct = 50;
        rst_n = 1'b0;
        limb_valid = 1'b0;
        limb_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_limb('0, 1'b1);
        send_limb(64'd1, 1'b1);
        send_limb('1, 1'b1);
        send_limb(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_limb(64'h8000_0000_0000_0000, 1'b1);
        send_limb(64'd10, 1'b1);
        // most negative two-limb value, forced end
        send_limb(64'h8000_0000_0000_0000, 1'b0);
        send_limb('0, 1'b0);
        send_limb(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_limb('1, 1'b1);
        send_limb('1, 1'b0);
        send_limb('1, 1'b0);
        send_limb('0, 1'b0);
        send_limb('0, 1'b1);
        // borrow runs into the upper limb
        send_limb('1, 1'b0);
        send_limb('0, 1'b1);
        send_limb('0, 1'b0);
        send_limb('1, 1'b0);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            idle_pct = (p == 0) ? 6 : (p == 1) ? 50 : 0;
            stall_pct = (p == 0) ? 50 : (p == 1) ? 6 : 0;
            while (sent < 28 * (p + 1))
            begin
                n = $urandom_range(1, SBDA_LIMBS);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(5))
                        0: v = LIMB_W'($urandom_range(999));
                        1: v = ~LIMB_W'($urandom_range(999));
                        2: v = '1;
                        3: v = '0;
                        4: v = {1'b1, {(LIMB_W-1){1'b0}}};
                        default: v = {$urandom, $urandom};
                    endcase
                    if (i != n - 1)
                        lst = 1'b0;
                    else if (n < SBDA_LIMBS)
                        lst = 1'b1;
                    else
                        lst = 1'($urandom_range(1));
                    send_limb(v, lst);
                    sent++;
                end
            end
            drain();
        end

        repeat (250) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
